FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the sequencer RTL.
// All checks are clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define BBOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define BBOS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/bbos_pkg.sv
// ----------------------------------------------------------------------------
// bbos_pkg
// Types and constants shared by the buck-boost output sequencer modules.
// ----------------------------------------------------------------------------
package bbos_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned MS_W    = 8;
  localparam int unsigned IN_MV_W = 16;
  localparam int unsigned MA_W    = 16;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned MV_W    = 14;

  localparam int unsigned SHADOW_COUNT_DEF = 10;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_REPLY = 2'd3
  } cmd_e;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS   = 3'd0,
    KIND_WRITE    = 3'd1,
    KIND_READ     = 3'd2,
    KIND_CONV_PIN = 3'd3,
    KIND_OUT_PIN  = 3'd4
  } kind_e;

  // Burst of results the back end plays out before the status item
  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_CONV_PIN = 3'd1,
    OP_OUT_PIN  = 3'd2,
    OP_WRITE1   = 3'd3,
    OP_WRITE4   = 3'd4,
    OP_READS    = 3'd5
  } op_e;

  // Register addresses used by the sequences
  localparam logic [ADDR_W-1:0] REG_OUT_CTRL = 4'd5;

  typedef struct packed {
    op_e                          op;
    logic [3:0][BYTE_W-1:0]       data;
    logic                         init_done;
    logic [STATE_W-1:0]           ctrl_state;
    logic [MV_W-1:0]              present_mv;
  } job_t;

  // Number of non-status results for a job
  function automatic logic [ADDR_W-1:0] job_body_count(op_e op, logic [ADDR_W-1:0] reads);
    logic [ADDR_W-1:0] n;
    case (op)
      OP_CONV_PIN: n = 4'd1;
      OP_OUT_PIN:  n = 4'd1;
      OP_WRITE1:   n = 4'd1;
      OP_WRITE4:   n = 4'd4;
      OP_READS:    n = reads;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: hw/rtl/bbos_front.sv
// ----------------------------------------------------------------------------
// bbos_front
// Accepts requests, runs the power-up and output control sequences and
// hands one job descriptor per request to the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbos_front #(
  parameter int unsigned SHADOW_COUNT = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bbos_pkg::CMD_W-1:0]    command_i,
  input  logic [bbos_pkg::MS_W-1:0]     elapsed_ms_i,
  input  logic [bbos_pkg::IN_MV_W-1:0]  target_mv_i,
  input  logic [bbos_pkg::MA_W-1:0]     current_ma_i,
  input  logic [bbos_pkg::ADDR_W-1:0]   reply_addr_i,
  input  logic [bbos_pkg::BYTE_W-1:0]   reply_data_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output bbos_pkg::job_t                job_o
);
  import bbos_pkg::*;

  localparam int unsigned SH_IDX_W = $clog2(SHADOW_COUNT);

  // Power-up sequence states
  localparam logic [2:0] PU_START = 3'd0;
  localparam logic [2:0] PU_WAIT  = 3'd1;
  localparam logic [2:0] PU_READ  = 3'd2;
  localparam logic [2:0] PU_SETTL = 3'd3;
  localparam logic [2:0] PU_DONE  = 3'd4;

  // Output control states
  localparam logic [2:0] CS_IDLE    = 3'd0;
  localparam logic [2:0] CS_OFF     = 3'd1;
  localparam logic [2:0] CS_OFF_END = 3'd2;
  localparam logic [2:0] CS_PROG    = 3'd3;
  localparam logic [2:0] CS_ARM     = 3'd4;
  localparam logic [2:0] CS_WAIT    = 3'd5;
  localparam logic [2:0] CS_ON      = 3'd6;

  localparam logic [MV_W-1:0] MV_MIN    = 14'd5000;
  localparam logic [MV_W-1:0] MV_MAX    = 14'd12000;
  localparam logic [MV_W-1:0] MV_OFFSET = 14'd4780;
  localparam logic [MS_W-1:0] PU_DELAY  = 8'd3;
  localparam logic [MS_W-1:0] COLD_DLY  = 8'd12;
  localparam logic [MS_W-1:0] WARM_DLY  = 8'd1;

  // Code for a zero target: offset wraps in 16 bits before the divide by 20
  localparam int unsigned CODE_ZERO_INT = ((65536 - 4780) % 65536) / 20;
  localparam logic [11:0] CODE_ZERO     = 12'(CODE_ZERO_INT);

  // x/5 as (x * 3277) >> 14, exact for x below 2048
  localparam logic [11:0] RECIP5_14 = 12'd3277;
  // y/5 as (y * 838861) >> 22, exact for y below 2^18
  localparam logic [19:0] RECIP5_22 = 20'd838861;

  logic [2:0]        pu_q, pu_d;
  logic [2:0]        cs_q, cs_d;
  logic [MS_W-1:0]   delay_q, delay_d;
  logic [MV_W-1:0]   wanted_q, wanted_d;
  logic [BYTE_W-1:0] cur_code_q, cur_code_d;
  logic [MV_W-1:0]   applied_q, applied_d;
  logic [MV_W-1:0]   programmed_q, programmed_d;
  logic [3:0]        seen_q, seen_d;
  logic [BYTE_W-1:0] shadow_q [SHADOW_COUNT];

  logic              cnt_zero;
  logic [MS_W-1:0]   cnt_next;
  logic [MV_W-1:0]   clamped_mv;
  logic [MV_W-1:0]   mv_diff;
  logic [22:0]       code_prod;
  logic [11:0]       volt_code;
  logic [37:0]       ma_prod;
  logic              reply_ok;
  logic [SH_IDX_W-1:0] reply_idx;
  job_t              job;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Shared delay countdown, saturating at zero
  assign cnt_zero = (delay_q <= elapsed_ms_i);
  assign cnt_next = cnt_zero ? '0 : delay_q - elapsed_ms_i;

  // Clamp requested voltage
  always_comb begin
    if (target_mv_i < IN_MV_W'(MV_MIN)) begin
      clamped_mv = MV_MIN;
    end else if (target_mv_i > IN_MV_W'(MV_MAX)) begin
      clamped_mv = MV_MAX;
    end else begin
      clamped_mv = target_mv_i[MV_W-1:0];
    end
  end

  // Voltage code (wanted - 4780) / 20; wanted is zero or 5000..12000
  assign mv_diff   = wanted_q - MV_OFFSET;
  assign code_prod = 23'(mv_diff[12:2]) * 23'(RECIP5_14);
  assign volt_code = (wanted_q == '0) ? CODE_ZERO : 12'(code_prod[22:14]);

  // Current code: (ma * 4 / 5) mod 256
  assign ma_prod = 38'({current_ma_i, 2'b00}) * 38'(RECIP5_22);

  assign reply_ok  = (reply_addr_i != '0) && (32'(reply_addr_i) <= SHADOW_COUNT);
  assign reply_idx = SH_IDX_W'(reply_addr_i - 4'd1);

  // Sequence and state update for one request
  always_comb begin
    pu_d         = pu_q;
    cs_d         = cs_q;
    delay_d      = delay_q;
    wanted_d     = wanted_q;
    cur_code_d   = cur_code_q;
    applied_d    = applied_q;
    programmed_d = programmed_q;
    seen_d       = seen_q;
    job          = '0;
    job.op       = OP_NONE;

    case (command_i)
      CMD_TICK: begin
        if (pu_q < PU_DONE) begin
          case (pu_q)
            PU_START: begin
              job.op  = OP_CONV_PIN;
              delay_d = PU_DELAY;
              pu_d    = PU_WAIT;
            end
            PU_WAIT: begin
              delay_d = cnt_next;
              if (cnt_zero) begin
                pu_d   = PU_READ;
                job.op = OP_READS;
              end
            end
            PU_READ: begin
              pu_d        = PU_SETTL;
              job.op      = OP_WRITE1;
              job.data[0] = shadow_q[4] | 8'h04;
            end
            default: begin
              pu_d = PU_DONE;
            end
          endcase
        end else begin
          case (cs_q)
            CS_OFF: begin
              job.op      = OP_WRITE1;
              job.data[0] = shadow_q[4] | 8'h04;
              cs_d        = CS_OFF_END;
            end
            CS_OFF_END: begin
              cs_d      = CS_IDLE;
              wanted_d  = '0;
              applied_d = '0;
            end
            CS_PROG: begin
              job.op       = OP_WRITE4;
              job.data[0]  = cur_code_q;
              job.data[1]  = shadow_q[1] | 8'h02;
              job.data[2]  = volt_code[9:2];
              job.data[3]  = ((shadow_q[3] & 8'he0) | 8'h18) + 8'(volt_code[1:0]);
              programmed_d = wanted_q;
              cs_d         = CS_ARM;
            end
            CS_ARM: begin
              cs_d    = CS_WAIT;
              delay_d = (applied_q == '0) ? COLD_DLY : WARM_DLY;
            end
            CS_WAIT: begin
              delay_d = cnt_next;
              if (cnt_zero) begin
                cs_d        = CS_ON;
                job.op      = OP_WRITE1;
                job.data[0] = (shadow_q[4] & 8'hfb) | 8'h02;
              end
            end
            CS_ON: begin
              applied_d = programmed_q;
              job.op    = OP_OUT_PIN;
              if (programmed_q != wanted_q) begin
                cs_d = (wanted_q != '0) ? CS_PROG : CS_OFF;
              end else begin
                cs_d = CS_IDLE;
              end
            end
            default: begin
              cs_d = cs_q;
            end
          endcase
        end
      end
      CMD_SET: begin
        wanted_d   = clamped_mv;
        cur_code_d = ma_prod[29:22];
        if (cs_q == CS_IDLE) begin
          cs_d = CS_PROG;
        end
      end
      CMD_CLOSE: begin
        wanted_d = '0;
        if (cs_q == CS_IDLE) begin
          cs_d = CS_OFF;
        end
      end
      default: begin
        if (reply_ok && (seen_q != 4'hf)) begin
          seen_d = seen_q + 4'd1;
        end
      end
    endcase

    job.init_done  = (pu_d == PU_DONE);
    job.ctrl_state = cs_d;
    job.present_mv = applied_d;
  end

  assign job_o = job;

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pu_q         <= PU_START;
      cs_q         <= CS_IDLE;
      delay_q      <= '0;
      wanted_q     <= '0;
      cur_code_q   <= '0;
      applied_q    <= '0;
      programmed_q <= '0;
      seen_q       <= '0;
    end else if (push_o) begin
      pu_q         <= pu_d;
      cs_q         <= cs_d;
      delay_q      <= delay_d;
      wanted_q     <= wanted_d;
      cur_code_q   <= cur_code_d;
      applied_q    <= applied_d;
      programmed_q <= programmed_d;
      seen_q       <= seen_d;
    end
  end

  // Shadow copy of converter registers, filled by read replies
  always_ff @(posedge clk_i) begin
    if (push_o && (command_i == CMD_REPLY) && reply_ok) begin
      shadow_q[reply_idx] <= reply_data_i;
    end
  end

  `BBOS_ASSERT(a_init_sticky, (pu_q == PU_DONE) |=> (pu_q == PU_DONE), "power-up left done state")
  `BBOS_ASSERT(a_applied_range, (applied_q == '0) || ((applied_q >= MV_MIN) && (applied_q <= MV_MAX)), "applied voltage out of range")
  `BBOS_ASSERT_NEVER(a_ctrl_early, (pu_q != PU_DONE) && (cs_q > CS_PROG), "control ran before power-up")

endmodule

FILE: hw/rtl/bbos_queue.sv
// ----------------------------------------------------------------------------
// bbos_queue
// Short FIFO of job descriptors between the front and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbos_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bbos_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bbos_pkg::job_t pop_data_o
);
  import bbos_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_FULL);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Descriptor storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `BBOS_ASSERT_NEVER(a_pop_empty, pop_i && (cnt_q == '0), "pop from empty queue")

endmodule

FILE: hw/rtl/bbos_back.sv
// ----------------------------------------------------------------------------
// bbos_back
// Plays out one job as its result burst followed by the status item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbos_back #(
  parameter int unsigned SHADOW_COUNT = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  bbos_pkg::job_t                q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bbos_pkg::KIND_W-1:0]   kind_o,
  output logic [bbos_pkg::ADDR_W-1:0]   reg_addr_o,
  output logic [bbos_pkg::BYTE_W-1:0]   reg_data_o,
  output logic                          init_done_o,
  output logic [bbos_pkg::STATE_W-1:0]  output_state_o,
  output logic [bbos_pkg::MV_W-1:0]     present_mv_o,
  output logic                          last_o
);
  import bbos_pkg::*;

  localparam logic [ADDR_W-1:0] READ_COUNT = ADDR_W'(SHADOW_COUNT);

  job_t              cur_q;
  logic              busy_q;
  logic [ADDR_W-1:0] idx_q;
  logic [ADDR_W-1:0] body_cnt;
  logic              is_status;
  logic              take;

  assign body_cnt  = job_body_count(cur_q.op, READ_COUNT);
  assign is_status = (idx_q == body_cnt);
  assign take      = busy_q && out_ready_i;
  assign pop_o     = q_valid_i && (!busy_q || (take && is_status));

  // Current job and result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      if (is_status) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
  end

  // Result fields for the current index
  always_comb begin
    kind_o         = KIND_STATUS;
    reg_addr_o     = '0;
    reg_data_o     = '0;
    init_done_o    = 1'b0;
    output_state_o = '0;
    present_mv_o   = '0;
    last_o         = 1'b0;
    if (is_status) begin
      init_done_o    = cur_q.init_done;
      output_state_o = cur_q.ctrl_state;
      present_mv_o   = cur_q.present_mv;
      last_o         = 1'b1;
    end else begin
      case (cur_q.op)
        OP_CONV_PIN: kind_o = KIND_CONV_PIN;
        OP_OUT_PIN:  kind_o = KIND_OUT_PIN;
        OP_WRITE1: begin
          kind_o     = KIND_WRITE;
          reg_addr_o = REG_OUT_CTRL;
          reg_data_o = cur_q.data[0];
        end
        OP_WRITE4: begin
          kind_o     = KIND_WRITE;
          reg_addr_o = idx_q + 4'd1;
          reg_data_o = cur_q.data[idx_q[1:0]];
        end
        OP_READS: begin
          kind_o     = KIND_READ;
          reg_addr_o = idx_q + 4'd1;
        end
        default: kind_o = KIND_STATUS;
      endcase
    end
  end

  assign out_valid_o = busy_q;

  `BBOS_ASSERT(a_idx_bound, busy_q |-> (idx_q <= body_cnt), "result index past end of job")

endmodule

FILE: hw/rtl/buck_boost_output_sequencer_top.sv
// ----------------------------------------------------------------------------
// buck_boost_output_sequencer_top
// Buck-boost converter output sequencer: requests in, register traffic out.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one request per handshake:
// a tick with elapsed milliseconds, a set-output request, a close request
// or a register read reply. Output channel (out_valid_o/out_ready_i) gives
// the results of each request in order: register reads and writes, pin
// events, then one status item flagged by last_o.
// The front end updates all sequence state in the cycle a request is taken
// and posts a job into a two-entry queue; the back end plays it out at one
// result per cycle while the receiver is ready, the first result once the
// job has passed the queue into the back end. A request yields 1 to
// SHADOW_COUNT+1 results (11 at most with the default); the front keeps
// accepting while the queue has room, so a stalled receiver holds results
// and backs up the input only once the queue fills.
// Reset clears both sequences, counters and queue; the shadow register copy
// holds nothing until read replies fill it.
// ----------------------------------------------------------------------------
module buck_boost_output_sequencer_top #(
  parameter int unsigned SHADOW_COUNT = bbos_pkg::SHADOW_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bbos_pkg::CMD_W-1:0]    command_i,
  input  logic [bbos_pkg::MS_W-1:0]     elapsed_ms_i,
  input  logic [bbos_pkg::IN_MV_W-1:0]  target_mv_i,
  input  logic [bbos_pkg::MA_W-1:0]     current_ma_i,
  input  logic [bbos_pkg::ADDR_W-1:0]   reply_addr_i,
  input  logic [bbos_pkg::BYTE_W-1:0]   reply_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bbos_pkg::KIND_W-1:0]   kind_o,
  output logic [bbos_pkg::ADDR_W-1:0]   reg_addr_o,
  output logic [bbos_pkg::BYTE_W-1:0]   reg_data_o,
  output logic                          init_done_o,
  output logic [bbos_pkg::STATE_W-1:0]  output_state_o,
  output logic [bbos_pkg::MV_W-1:0]     present_mv_o,
  output logic                          last_o
);
  import bbos_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic q_valid;
  job_t push_job;
  job_t pop_job;

  bbos_front #(
    .SHADOW_COUNT(SHADOW_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .elapsed_ms_i (elapsed_ms_i),
    .target_mv_i  (target_mv_i),
    .current_ma_i (current_ma_i),
    .reply_addr_i (reply_addr_i),
    .reply_data_i (reply_data_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  bbos_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  bbos_back #(
    .SHADOW_COUNT(SHADOW_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (pop_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .reg_addr_o     (reg_addr_o),
    .reg_data_o     (reg_data_o),
    .init_done_o    (init_done_o),
    .output_state_o (output_state_o),
    .present_mv_o   (present_mv_o),
    .last_o         (last_o)
  );

endmodule

FILE: bench/bbos_sequence_checker.sv
// ----------------------------------------------------------------------------
// bbos_sequence_checker
// Watches both channels of the output sequencer, predicts the register and
// pin traffic of every accepted request, and compares each result in order.
// ----------------------------------------------------------------------------
module bbos_sequence_checker #(
  parameter int unsigned SHADOW_COUNT = bbos_pkg::SHADOW_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [bbos_pkg::CMD_W-1:0]    command_i,
  input  logic [bbos_pkg::MS_W-1:0]     elapsed_ms_i,
  input  logic [bbos_pkg::IN_MV_W-1:0]  target_mv_i,
  input  logic [bbos_pkg::MA_W-1:0]     current_ma_i,
  input  logic [bbos_pkg::ADDR_W-1:0]   reply_addr_i,
  input  logic [bbos_pkg::BYTE_W-1:0]   reply_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [bbos_pkg::KIND_W-1:0]   kind_i,
  input  logic [bbos_pkg::ADDR_W-1:0]   reg_addr_i,
  input  logic [bbos_pkg::BYTE_W-1:0]   reg_data_i,
  input  logic                          init_done_i,
  input  logic [bbos_pkg::STATE_W-1:0]  output_state_i,
  input  logic [bbos_pkg::MV_W-1:0]     present_mv_i,
  input  logic                          last_i,
  output int unsigned                   errors_o,
  output int unsigned                   pending_o
);
  import bbos_pkg::*;

  // Power-up sequence states
  localparam logic [2:0] PU_START   = 3'd0;
  localparam logic [2:0] PU_WAIT    = 3'd1;
  localparam logic [2:0] PU_DISABLE = 3'd2;
  localparam logic [2:0] PU_LAST    = 3'd3;
  localparam logic [2:0] PU_DONE    = 3'd4;

  // Output control states
  localparam logic [STATE_W-1:0] CTL_IDLE    = 3'd0;
  localparam logic [STATE_W-1:0] CTL_CLOSE   = 3'd1;
  localparam logic [STATE_W-1:0] CTL_OFF     = 3'd2;
  localparam logic [STATE_W-1:0] CTL_PROGRAM = 3'd3;
  localparam logic [STATE_W-1:0] CTL_ARM     = 3'd4;
  localparam logic [STATE_W-1:0] CTL_SETTLE  = 3'd5;
  localparam logic [STATE_W-1:0] CTL_ENABLE  = 3'd6;

  // Converter registers
  localparam logic [ADDR_W-1:0] REG_ILIM    = 4'd1;
  localparam logic [ADDR_W-1:0] REG_CFG     = 4'd2;
  localparam logic [ADDR_W-1:0] REG_VOUT_HI = 4'd3;
  localparam logic [ADDR_W-1:0] REG_VOUT_LO = 4'd4;

  // Register bit patterns
  localparam logic [BYTE_W-1:0] OUT_OFF_BIT = 8'h04;
  localparam logic [BYTE_W-1:0] OUT_ON_KEEP = 8'hFB;
  localparam logic [BYTE_W-1:0] OUT_ON_BIT  = 8'h02;
  localparam logic [BYTE_W-1:0] CFG_BIT     = 8'h02;
  localparam logic [BYTE_W-1:0] LO_KEEP     = 8'hE0;
  localparam logic [BYTE_W-1:0] LO_BASE     = 8'h18;

  // Voltage scaling and delays
  localparam int unsigned MV_MIN    = 5000;
  localparam int unsigned MV_MAX    = 12000;
  localparam int unsigned MV_OFFSET = 4780;
  localparam int unsigned MV_STEP   = 20;
  localparam logic [MS_W-1:0] DELAY_POWER_UP = 8'd3;
  localparam logic [MS_W-1:0] DELAY_COLD     = 8'd12;
  localparam logic [MS_W-1:0] DELAY_WARM     = 8'd1;

  typedef struct packed {
    kind_e               kind;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   data;
    logic                init_done;
    logic [STATE_W-1:0]  state;
    logic [MV_W-1:0]     mv;
    logic                last;
  } bus_event_t;

  bus_event_t bus_events_q[$];
  bus_event_t want;
  int unsigned mismatch_cnt;

  // Predicted sequencer state
  logic [2:0]          pu_state;
  logic [STATE_W-1:0]  ctl_state;
  logic [MS_W-1:0]     delay_ms;
  logic [MV_W-1:0]     wanted_mv;
  logic [BYTE_W-1:0]   current_code;
  logic [MV_W-1:0]     applied_mv;
  logic [MV_W-1:0]     programmed_mv;
  logic [BYTE_W-1:0]   shadow [SHADOW_COUNT];

  function automatic void push_event(kind_e kind, logic [ADDR_W-1:0] addr,
                                     logic [BYTE_W-1:0] data);
    bus_event_t ev;
    ev = '0;
    ev.kind = kind;
    ev.addr = addr;
    ev.data = data;
    bus_events_q.push_back(ev);
  endfunction

  // Shared delay counter: drop by elapsed time, saturate at zero
  function automatic logic delay_expired(logic [MS_W-1:0] ms);
    if (delay_ms > ms) delay_ms = delay_ms - ms;
    else delay_ms = '0;
    return delay_ms == '0;
  endfunction

  // Advance the predicted sequencer by one request, queueing its traffic
  task automatic sequence_step(cmd_e cmd, logic [MS_W-1:0] ms,
                               logic [IN_MV_W-1:0] mv, logic [MA_W-1:0] ma,
                               logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
    int unsigned code;
    int unsigned i;
    bus_event_t status;
    case (cmd)
      CMD_TICK: begin
        if (pu_state < PU_DONE) begin
          case (pu_state)
            PU_START: begin
              push_event(KIND_CONV_PIN, '0, '0);
              delay_ms = DELAY_POWER_UP;
              pu_state = PU_WAIT;
            end
            PU_WAIT: begin
              if (delay_expired(ms)) begin
                pu_state = PU_DISABLE;
                for (i = 0; i < SHADOW_COUNT; i++) push_event(KIND_READ, ADDR_W'(i + 1), '0);
              end
            end
            PU_DISABLE: begin
              pu_state = PU_LAST;
              push_event(KIND_WRITE, REG_OUT_CTRL, shadow[4] | OUT_OFF_BIT);
            end
            PU_LAST: pu_state = PU_DONE;
            default: ;
          endcase
        end else begin
          case (ctl_state)
            CTL_CLOSE: begin
              push_event(KIND_WRITE, REG_OUT_CTRL, shadow[4] | OUT_OFF_BIT);
              ctl_state = CTL_OFF;
            end
            CTL_OFF: begin
              ctl_state = CTL_IDLE;
              wanted_mv = '0;
              applied_mv = '0;
            end
            CTL_PROGRAM: begin
              // a zero target after a close wraps below the offset
              code = ((32'(wanted_mv) - MV_OFFSET) & 32'hFFFF) / MV_STEP;
              push_event(KIND_WRITE, REG_ILIM, current_code);
              push_event(KIND_WRITE, REG_CFG, shadow[1] | CFG_BIT);
              push_event(KIND_WRITE, REG_VOUT_HI, 8'(code / 4));
              push_event(KIND_WRITE, REG_VOUT_LO,
                         8'(32'((shadow[3] & LO_KEEP) | LO_BASE) + code % 4));
              programmed_mv = wanted_mv;
              ctl_state = CTL_ARM;
            end
            CTL_ARM: begin
              ctl_state = CTL_SETTLE;
              delay_ms = (applied_mv == '0) ? DELAY_COLD : DELAY_WARM;
            end
            CTL_SETTLE: begin
              if (delay_expired(ms)) begin
                ctl_state = CTL_ENABLE;
                push_event(KIND_WRITE, REG_OUT_CTRL, (shadow[4] & OUT_ON_KEEP) | OUT_ON_BIT);
              end
            end
            CTL_ENABLE: begin
              applied_mv = programmed_mv;
              if (programmed_mv != wanted_mv)
                ctl_state = (wanted_mv != '0) ? CTL_PROGRAM : CTL_CLOSE;
              else
                ctl_state = CTL_IDLE;
              push_event(KIND_OUT_PIN, '0, '0);
            end
            default: ;
          endcase
        end
      end
      CMD_SET: begin
        if (32'(mv) < MV_MIN) wanted_mv = MV_W'(MV_MIN);
        else if (32'(mv) > MV_MAX) wanted_mv = MV_W'(MV_MAX);
        else wanted_mv = MV_W'(mv);
        current_code = 8'((32'(ma) * 4) / 5);
        if (ctl_state == CTL_IDLE) ctl_state = CTL_PROGRAM;
      end
      CMD_CLOSE: begin
        if (ctl_state == CTL_IDLE) ctl_state = CTL_CLOSE;
        wanted_mv = '0;
      end
      default: begin
        if (addr >= 1 && 32'(addr) <= SHADOW_COUNT) shadow[addr - 1] = data;
      end
    endcase

    // every request ends with one status item
    status = '0;
    status.kind = KIND_STATUS;
    status.init_done = (pu_state == PU_DONE);
    status.state = ctl_state;
    status.mv = applied_mv;
    status.last = 1'b1;
    bus_events_q.push_back(status);
  endtask

  // Compare taken results first, then predict for a taken request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_events_q.delete();
      mismatch_cnt = 0;
      pu_state = PU_START;
      ctl_state = CTL_IDLE;
      delay_ms = '0;
      wanted_mv = '0;
      current_code = '0;
      applied_mv = '0;
      programmed_mv = '0;
      for (int k = 0; k < SHADOW_COUNT; k++) shadow[k] = '0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (bus_events_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: kind %0d addr %0d data %02h last %0d",
                     kind_i, reg_addr_i, reg_data_i, last_i);
        end else begin
          want = bus_events_q.pop_front();
          if (kind_i !== want.kind || reg_addr_i !== want.addr ||
              reg_data_i !== want.data || init_done_i !== want.init_done ||
              output_state_i !== want.state || present_mv_i !== want.mv ||
              last_i !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"result mismatch: expected kind %0d addr %0d data %02h init %0d ",
                        "state %0d mv %0d last %0d, got kind %0d addr %0d data %02h ",
                        "init %0d state %0d mv %0d last %0d"},
                       want.kind, want.addr, want.data, want.init_done, want.state,
                       want.mv, want.last, kind_i, reg_addr_i, reg_data_i, init_done_i,
                       output_state_i, present_mv_i, last_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        sequence_step(cmd_e'(command_i), elapsed_ms_i, target_mv_i, current_ma_i,
                      reply_addr_i, reply_data_i);
      errors_o <= mismatch_cnt;
      pending_o <= bus_events_q.size();
    end
  end

endmodule

FILE: bench/buck_boost_output_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// buck_boost_output_sequencer_top_tb
// Drives ticks, set and close requests and read replies into the sequencer,
// with random gaps on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module buck_boost_output_sequencer_top_tb;
  import bbos_pkg::*;

  localparam int unsigned SHADOW_COUNT = SHADOW_COUNT_DEF;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i = '0;
  logic [MS_W-1:0]     elapsed_ms_i = '0;
  logic [IN_MV_W-1:0]  target_mv_i = '0;
  logic [MA_W-1:0]     current_ma_i = '0;
  logic [ADDR_W-1:0]   reply_addr_i = '0;
  logic [BYTE_W-1:0]   reply_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [KIND_W-1:0]   kind_o;
  logic [ADDR_W-1:0]   reg_addr_o;
  logic [BYTE_W-1:0]   reg_data_o;
  logic                init_done_o;
  logic [STATE_W-1:0]  output_state_o;
  logic [MV_W-1:0]     present_mv_o;
  logic                last_o;

  int unsigned tx_idle_pct = 22;
  int unsigned rx_idle_pct = 86;
  int unsigned cycle_cnt = 0;
  int unsigned errors;
  int unsigned pending;

  always #10 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  buck_boost_output_sequencer_top #(
    .SHADOW_COUNT(SHADOW_COUNT)
  ) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .elapsed_ms_i,
    .target_mv_i, .current_ma_i, .reply_addr_i, .reply_data_i, .out_valid_o,
    .out_ready_i, .kind_o, .reg_addr_o, .reg_data_o, .init_done_o,
    .output_state_o, .present_mv_o, .last_o
  );

  bbos_sequence_checker #(
    .SHADOW_COUNT(SHADOW_COUNT)
  ) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .command_i,
    .elapsed_ms_i, .target_mv_i, .current_ma_i, .reply_addr_i, .reply_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .kind_i(kind_o),
    .reg_addr_i(reg_addr_o), .reg_data_i(reg_data_o), .init_done_i(init_done_o),
    .output_state_i(output_state_o), .present_mv_i(present_mv_o),
    .last_i(last_o), .errors_o(errors), .pending_o(pending)
  );

  // One request: optional idle gap, then hold valid until taken.
  // Called and returns at a rising edge.
  task automatic send_request(cmd_e cmd, logic [MS_W-1:0] ms, logic [IN_MV_W-1:0] mv,
                              logic [MA_W-1:0] ma, logic [ADDR_W-1:0] addr,
                              logic [BYTE_W-1:0] data);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    elapsed_ms_i <= ms;
    target_mv_i  <= mv;
    current_ma_i <= ma;
    reply_addr_i <= addr;
    reply_data_i <= data;
    // ready is settled mid-cycle; the edge after a high ready takes the request
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Unused fields get random content
  task automatic send_tick(logic [MS_W-1:0] ms);
    send_request(CMD_TICK, ms, 16'($urandom), 16'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic send_set(logic [IN_MV_W-1:0] mv, logic [MA_W-1:0] ma);
    send_request(CMD_SET, 8'($urandom), mv, ma, 4'($urandom), 8'($urandom));
  endtask

  task automatic send_reply(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
    send_request(CMD_REPLY, 8'($urandom), 16'($urandom), 16'($urandom), addr, data);
  endtask

  // Mostly ticks so the sequences run through, with sets, closes and replies
  // mixed in, plus some fully random requests as noise
  task automatic run_random(int unsigned count);
    int unsigned done;
    int unsigned pick;
    logic [ADDR_W-1:0] addr;
    logic [IN_MV_W-1:0] mv;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_tick(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)));
        done++;
      end else if (pick < 70) begin
        mv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(4900, 12100));
        send_set(mv, 16'($urandom));
        done++;
      end else if (pick < 77) begin
        send_request(CMD_CLOSE, 8'($urandom), 16'($urandom), 16'($urandom),
                     4'($urandom), 8'($urandom));
        done++;
      end else if (pick < 92) begin
        addr = 4'($urandom);
        send_reply(addr, 8'($urandom));
        // replies to unknown addresses are dropped by the block
        if (addr != 0 && 32'(addr) <= SHADOW_COUNT) done++;
      end else begin
        send_request(cmd_e'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                     16'($urandom), 4'($urandom), 8'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every shadow entry before any tick can read one
    for (int k = 1; k <= SHADOW_COUNT; k++) send_reply(4'(k), (k % 2 == 1) ? 8'hFF : 8'h00);
    // Replies outside the shadow range are ignored
    send_reply(4'd0, 8'hFF);
    send_reply(4'd15, 8'h00);
    // Set before power-up has finished, voltage below the floor
    send_set(16'd0, 16'hFFFF);
    // Power-up: enable pin, delay partly then past zero, reads, disable, done
    send_tick(8'd0);
    send_tick(8'd1);
    send_tick(8'd255);
    send_tick(8'd0);
    send_tick(8'd0);
    // Control run from cold: program, arm, settle exactly, output pin
    send_tick(8'd0);
    send_tick(8'd0);
    send_tick(8'd12);
    send_tick(8'd0);
    // Voltage above the ceiling, then a close before programming runs
    send_set(16'hFFFF, 16'd0);
    send_request(CMD_CLOSE, 8'($urandom), 16'($urandom), 16'($urandom),
                 4'($urandom), 8'($urandom));
    send_tick(8'd0);

    run_random(153);
    tx_idle_pct = 86;
    rx_idle_pct = 22;
    run_random(153);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(154);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
